### hdl/cfq_pkg.sv
// Shared definitions for the circular FIFO queue.
// Holds operation codes, field widths, reset and default constants and the status record; depends on nothing.
`default_nettype none
package cfq_pkg;

  localparam int OP_W             = 2;
  localparam int DATA_W           = 32;
  localparam int CAP_W            = 10;
  localparam int CAP_RESET        = 1023;
  localparam int MAX_CAPACITY_DEF = 1023;

  typedef enum logic [OP_W-1:0] {
    OP_QUERY   = 2'd0,
    OP_ENQUEUE = 2'd1,
    OP_DEQUEUE = 2'd2
  } op_t;

  typedef struct packed {
    logic valid;
    logic succeeded;
    logic is_empty;
    logic is_full;
  } status_t;

endpackage
`default_nettype wire

### hdl/circular_fifo_queue_top.sv
// Top level of the circular FIFO queue of 32-bit signed values.
// Uses cfq_pkg, cfq_ctrl and two cfq_ram instances.
`default_nettype none
// An operation (query, enqueue or dequeue) is accepted when start is high and busy
// is low. The enqueue write goes to the slot memories at the edge of acceptance, the
// read state that follows reads the head and newest slots, and the result is shown
// on the out_ ports for one cycle under out_valid, in the show state after it. The
// receiver cannot stall; it must take the transfer in that cycle. Busy is high only
// in the read state, so start may be raised again while a result is shown, though
// not while the slot memories are being read for the last operation. A write
// on the cfg_ channel, taken whenever busy and start are both low, sets the
// capacity and empties the queue.
module circular_fifo_queue_top #(
  parameter int MAX_CAPACITY = cfq_pkg::MAX_CAPACITY_DEF
) (
  input  wire logic                               clk,
  input  wire logic                               rst_n,
  input  wire logic                               start,
  output logic                                    busy,
  input  wire logic        [cfq_pkg::OP_W-1:0]    in_operation,
  input  wire logic signed [cfq_pkg::DATA_W-1:0]  in_value,
  output logic                                    out_valid,
  output logic                                    out_succeeded,
  output logic signed      [cfq_pkg::DATA_W-1:0]  out_head_value,
  output logic signed      [cfq_pkg::DATA_W-1:0]  out_tail_value,
  output logic                                    out_is_empty,
  output logic                                    out_is_full,
  input  wire logic                               cfg_valid,
  output logic                                    cfg_ready,
  input  wire logic        [cfq_pkg::CAP_W-1:0]   cfg_queue_capacity
);
  import cfq_pkg::*;

  localparam int IDX_W = $clog2(MAX_CAPACITY + 1);

  logic              wr_en;
  logic [IDX_W-1:0]  wr_addr, head_addr, last_addr;
  logic [DATA_W-1:0] head_q, tail_q;
  status_t           status;

  cfq_ctrl #(.MAX_CAPACITY(MAX_CAPACITY)) u_ctrl (
    .clk                (clk),
    .rst_n              (rst_n),
    .start              (start),
    .in_operation       (in_operation),
    .cfg_valid          (cfg_valid),
    .cfg_queue_capacity (cfg_queue_capacity),
    .busy               (busy),
    .cfg_ready          (cfg_ready),
    .wr_en              (wr_en),
    .wr_addr            (wr_addr),
    .head_addr          (head_addr),
    .last_addr          (last_addr),
    .status             (status)
  );

  cfq_ram #(.WIDTH(DATA_W), .DEPTH(MAX_CAPACITY + 1)) u_head_ram (
    .clk     (clk),
    .wr_en   (wr_en),
    .wr_addr (wr_addr),
    .wr_data (in_value),
    .rd_addr (head_addr),
    .rd_data (head_q)
  );

  cfq_ram #(.WIDTH(DATA_W), .DEPTH(MAX_CAPACITY + 1)) u_tail_ram (
    .clk     (clk),
    .wr_en   (wr_en),
    .wr_addr (wr_addr),
    .wr_data (in_value),
    .rd_addr (last_addr),
    .rd_data (tail_q)
  );

  assign out_valid      = status.valid;
  assign out_succeeded  = status.succeeded;
  assign out_is_empty   = status.is_empty;
  assign out_is_full    = status.is_full;
  assign out_head_value = status.is_empty ? '1 : head_q;
  assign out_tail_value = status.is_empty ? '1 : tail_q;

endmodule
`default_nettype wire

### hdl/cfq_ram.sv
// Generic single-write, single-read synchronous RAM with registered read data.
// Stands alone; no package needed.
`default_nettype none
module cfq_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 1024,
  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  wire logic             clk,
  input  wire logic             wr_en,
  input  wire logic [AW-1:0]    wr_addr,
  input  wire logic [WIDTH-1:0] wr_data,
  input  wire logic [AW-1:0]    rd_addr,
  output logic      [WIDTH-1:0] rd_data
);

  logic [WIDTH-1:0] mem_r [DEPTH];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem_r[wr_addr] <= wr_data;
    end
    rd_data <= mem_r[rd_addr];
  end

endmodule
`default_nettype wire

### hdl/cfq_ctrl.sv
// Index and sequencing control of the circular FIFO queue.
// Uses cfq_pkg; drives the write and read addresses of the slot memories.
`default_nettype none
module cfq_ctrl #(
  parameter int MAX_CAPACITY = cfq_pkg::MAX_CAPACITY_DEF,
  localparam int IDX_W = $clog2(MAX_CAPACITY + 1)
) (
  input  wire logic                     clk,
  input  wire logic                     rst_n,
  input  wire logic                     start,
  input  wire logic [cfq_pkg::OP_W-1:0] in_operation,
  input  wire logic                     cfg_valid,
  input  wire logic [cfq_pkg::CAP_W-1:0] cfg_queue_capacity,
  output logic                          busy,
  output logic                          cfg_ready,
  output logic                          wr_en,
  output logic      [IDX_W-1:0]         wr_addr,
  output logic      [IDX_W-1:0]         head_addr,
  output logic      [IDX_W-1:0]         last_addr,
  output cfq_pkg::status_t              status
);
  import cfq_pkg::*;

  localparam int CMP_W = (CAP_W > IDX_W) ? CAP_W : IDX_W;
  localparam int RST_CAP = (CAP_RESET > MAX_CAPACITY) ? MAX_CAPACITY : CAP_RESET;
  localparam logic [IDX_W-1:0] RST_WRAP = IDX_W'(RST_CAP);

  typedef enum logic [1:0] {ST_IDLE, ST_READ, ST_SHOW} st_t;

  st_t              st_r, st_nxt;
  logic [IDX_W-1:0] head_r, head_nxt;
  logic [IDX_W-1:0] tail_r, tail_nxt;
  logic [IDX_W-1:0] wrap_r, wrap_nxt;
  logic             succ_r, succ_nxt;
  logic             empty_r, empty_nxt;
  logic             full_r, full_nxt;
  logic [IDX_W-1:0] adv_head, adv_tail, cap_clamped;
  logic [CMP_W-1:0] cap_ext;
  logic             accept, cfg_write;
  op_t              op;

  assign busy      = (st_r == ST_READ);
  assign cfg_ready = !busy && !start;
  assign accept    = start && !busy;
  assign cfg_write = cfg_valid && cfg_ready;
  assign op        = op_t'(in_operation);

  assign adv_head  = (head_r == wrap_r) ? '0 : head_r + 1'b1;
  assign adv_tail  = (tail_r == wrap_r) ? '0 : tail_r + 1'b1;
  assign head_addr = head_r;
  assign last_addr = (tail_r == '0) ? wrap_r : tail_r - 1'b1;
  assign wr_addr   = tail_r;

  assign cap_ext = CMP_W'(cfg_queue_capacity);

  always_comb begin
    priority if (cap_ext == '0) begin
      cap_clamped = IDX_W'(1);
    end else if (cap_ext > CMP_W'(MAX_CAPACITY)) begin
      cap_clamped = IDX_W'(MAX_CAPACITY);
    end else begin
      cap_clamped = IDX_W'(cap_ext);
    end
  end

  always_comb begin
    st_nxt    = st_r;
    head_nxt  = head_r;
    tail_nxt  = tail_r;
    wrap_nxt  = wrap_r;
    succ_nxt  = succ_r;
    empty_nxt = empty_r;
    full_nxt  = full_r;
    wr_en     = 1'b0;
    unique case (st_r)
      ST_READ: begin
        st_nxt    = ST_SHOW;
        empty_nxt = (head_r == tail_r);
        full_nxt  = (adv_tail == head_r);
      end
      default: begin
        st_nxt = ST_IDLE;
        priority if (cfg_write) begin
          wrap_nxt = cap_clamped;
          head_nxt = '0;
          tail_nxt = '0;
        end else if (accept) begin
          st_nxt   = ST_READ;
          succ_nxt = 1'b1;
          unique case (op)
            OP_ENQUEUE: begin
              if (adv_tail == head_r) begin
                succ_nxt = 1'b0;
              end else begin
                wr_en    = 1'b1;
                tail_nxt = adv_tail;
              end
            end
            OP_DEQUEUE: begin
              if (head_r == tail_r) begin
                succ_nxt = 1'b0;
              end else begin
                head_nxt = adv_head;
              end
            end
            default: begin
              succ_nxt = 1'b1;
            end
          endcase
        end else begin
          st_nxt = ST_IDLE;
        end
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r    <= ST_IDLE;
      head_r  <= '0;
      tail_r  <= '0;
      wrap_r  <= RST_WRAP;
      succ_r  <= 1'b0;
      empty_r <= 1'b1;
      full_r  <= 1'b0;
    end else begin
      st_r    <= st_nxt;
      head_r  <= head_nxt;
      tail_r  <= tail_nxt;
      wrap_r  <= wrap_nxt;
      succ_r  <= succ_nxt;
      empty_r <= empty_nxt;
      full_r  <= full_nxt;
    end
  end

  assign status = '{valid: (st_r == ST_SHOW), succeeded: succ_r,
                    is_empty: empty_r, is_full: full_r};

  a_idx_in_ring: assert property (@(posedge clk) disable iff (!rst_n)
    (head_r <= wrap_r) && (tail_r <= wrap_r))
    else $error("Head or tail index lies outside the ring.");

  a_show_after_read: assert property (@(posedge clk) disable iff (!rst_n)
    (st_r == ST_SHOW) |-> $past(st_r) == ST_READ)
    else $error("Result shown without a preceding memory read.");

  a_enq_not_empty: assert property (@(posedge clk) disable iff (!rst_n)
    wr_en |=> (tail_r != head_r))
    else $error("Queue is empty right after a successful enqueue.");

  a_flags_exclusive: assert property (@(posedge clk) disable iff (!rst_n)
    status.valid |-> !(status.is_empty && status.is_full))
    else $error("Queue reported both empty and full.");

endmodule
`default_nettype wire
